// ===== hdl/itoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and the digit-to-character map for the integer to
// text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 32;

	// quotient bits resolved per divider cycle
	localparam int DIV_BITS = 4;

	localparam logic [4:0] RADIX_MIN   = 5'd2;
	localparam logic [4:0] RADIX_MAX   = 5'd16;
	localparam logic [7:0] MINUS_CHAR  = 8'h2D;
	localparam logic [7:0] ZERO_CHAR   = 8'h30;
	localparam logic [7:0] ALPHA_CHAR  = 8'h41;
	localparam logic [3:0] DIGIT_LIMIT = 4'd9;
	localparam logic [3:0] ALPHA_BASE  = 4'd10;

	typedef struct packed {
		logic       done;
		logic [3:0] rem;
	} div_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] ch;
		if (d > DIGIT_LIMIT)
			ch = ALPHA_CHAR + {4'd0, d - ALPHA_BASE};
		else
			ch = ZERO_CHAR + {4'd0, d};
		return ch;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/itoa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels: the input word (value, radix) and the output word
// (one character).
// ----------------------------------------------------------------------------
interface itoa_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [4:0]  radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itoa_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	logic       bad_radix;

	modport source (output valid, output character, output last, output bad_radix,
		input ready);
	modport sink   (input valid, input character, input last, input bad_radix,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/int_to_ascii_radix_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_ascii_radix_top
// Integer to ASCII text in radix 2 to 16, most significant character first.
//
// channel  dir  words                          fields
// item     in   one per conversion             value[31:0], radix[4:0]
// text     out  sign, digits; or one error     character[7:0], last, bad_radix
//
// Bad radix: one word. Digits come from the shared divider (4 quotient bits per
// cycle) and are read back through the registered digit buffer.
// item.ready is low for the whole conversion. A stall on text holds the sequencer.
// Reset clears the sequencer, the output valid and the divider step count; the
// digit buffer and the output word are not reset.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_top
	import itoa_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	itoa_item_if.sink item,
	itoa_text_if.source text
);

	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DGO   = 3'd1;
	localparam logic [2:0] S_DWAIT = 3'd2;
	localparam logic [2:0] S_SIGN  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [4:0]            radix_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      cnt_nxt;
	logic [CNT_W-1:0]      rd_idx;

	logic                  o_valid_q;
	logic [7:0]            o_char_q;
	logic                  o_last_q;
	logic                  o_bad_q;
	logic                  out_free;
	logic                  o_load;

	logic [63:0]           val_wide;
	logic [VALUE_BITS-1:0] val;
	logic                  val_neg;
	logic                  radix_bad;

	logic                  div_start;
	logic [VALUE_BITS-1:0] quot;
	div_stat_t             dstat;
	logic                  dig_we;
	logic [3:0]            dig_rd;

	assign out_free  = !o_valid_q || text.ready;
	assign item.ready = (state_q == S_IDLE) && out_free;

	assign val_wide  = {32'd0, item.value};
	assign val       = val_wide[VALUE_BITS-1:0];
	assign val_neg   = val[VALUE_BITS-1];
	assign radix_bad = (item.radix < RADIX_MIN) || (item.radix > RADIX_MAX);

	assign o_load    = (state_q == S_IDLE && item.valid && item.ready && radix_bad) ||
		((state_q == S_SIGN || state_q == S_PUT) && out_free);

	assign div_start = (state_q == S_DGO);
	assign dig_we    = (state_q == S_DWAIT) && dstat.done;
	assign cnt_nxt   = cnt_q + CNT_ONE;
	assign rd_idx    = idx_q - CNT_ONE;

	itoa_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (radix_q),
		.quotient (quot),
		.stat     (dstat)
	);

	itoa_dbuf #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dbuf (
		.clk   (clk),
		.we    (dig_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (dstat.rem),
		.raddr (rd_idx[IDX_W-1:0]),
		.rdata (dig_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			radix_q   <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (o_load)
				o_valid_q <= 1'b1;
			else if (text.ready)
				o_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item.valid && item.ready && !radix_bad) begin
						neg_q   <= val_neg;
						mag_q   <= val_neg ? (~val + VALUE_BITS'(1)) : val;
						radix_q <= item.radix;
						cnt_q   <= '0;
						state_q <= S_DGO;
					end
				end
				S_DGO: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (dstat.done) begin
						cnt_q <= cnt_nxt;
						mag_q <= quot;
						if (quot == '0 || cnt_nxt == CNT_MAX) begin
							idx_q   <= cnt_nxt;
							state_q <= neg_q ? S_SIGN : S_READ;
						end else begin
							state_q <= S_DGO;
						end
					end
				end
				S_SIGN: begin
					if (out_free)
						state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						idx_q   <= rd_idx;
						state_q <= (idx_q == CNT_ONE) ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid && item.ready && radix_bad) begin
			o_char_q <= '0;
			o_last_q <= 1'b1;
			o_bad_q  <= 1'b1;
		end else if (state_q == S_SIGN && out_free) begin
			o_char_q <= MINUS_CHAR;
			o_last_q <= 1'b0;
			o_bad_q  <= 1'b0;
		end else if (state_q == S_PUT && out_free) begin
			o_char_q <= digit_char(dig_rd);
			o_last_q <= (idx_q == CNT_ONE);
			o_bad_q  <= 1'b0;
		end
	end

	assign text.valid     = o_valid_q;
	assign text.character = o_char_q;
	assign text.last      = o_last_q;
	assign text.bad_radix = o_bad_q;

`ifndef SYNTHESIS
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DWAIT && dstat.done) |-> ({1'b0, dstat.rem} < radix_q))
		else $error("digit not below radix");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (state_q == S_IDLE))
		else $error("input taken during conversion");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.bad_radix) |-> (text.last && text.character == '0))
		else $error("error word malformed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_MAX) && (idx_q <= CNT_MAX))
		else $error("digit count beyond buffer");

	a_put_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ || state_q == S_PUT) |-> (idx_q != '0))
		else $error("emit with no digits left");
`endif

endmodule
`default_nettype wire

// ===== hdl/itoa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_div
// Shared iterative divider: magnitude by radix, DIV_BITS quotient bits per
// cycle, restoring compare and subtract on a 5-bit partial remainder.
// ----------------------------------------------------------------------------
module itoa_div
	import itoa_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [4:0]            divisor,
	output logic      [VALUE_BITS-1:0] quotient,
	output div_stat_t                  stat
);

	localparam int NSTEP = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int PADW  = NSTEP * DIV_BITS;
	localparam int SW    = $clog2(NSTEP + 1);

	logic [PADW-1:0] work_q, work_d;
	logic [3:0]      rem_q, rem_d;
	logic [SW-1:0]   step_q;
	logic            done_q;

	always_comb begin
		logic [4:0] r5;
		logic [PADW-1:0] w;
		logic [3:0] r;
		w = work_q;
		r = rem_q;
		for (int j = 0; j < DIV_BITS; j++) begin
			r5 = {r, w[PADW-1]};
			w  = {w[PADW-2:0], 1'b0};
			if (r5 >= divisor) begin
				r5   = r5 - divisor;
				w[0] = 1'b1;
			end
			r = r5[3:0];
		end
		work_d = w;
		rem_d  = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == SW'(1));
			if (start)
				step_q <= SW'(NSTEP);
			else if (step_q != '0)
				step_q <= step_q - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PADW'(dividend);
			rem_q  <= '0;
		end else if (step_q != '0) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign quotient  = work_q[VALUE_BITS-1:0];
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule
`default_nettype wire

// ===== hdl/itoa_dbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_dbuf
// Digit buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itoa_dbuf
	import itoa_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(MAX_DIGITS)-1:0] waddr,
	input  wire logic [3:0]                    wdata,
	input  wire logic [$clog2(MAX_DIGITS)-1:0] raddr,
	output logic      [3:0]                    rdata
);

	logic [3:0] mem [MAX_DIGITS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for int_to_ascii_radix_top. Directed rows and then
// random numbers are fed on the item channel. Each accepted number takes its
// expected text from its row or from a local model of the conversion, and
// every word on the text channel is matched against that text. Four pacing
// phases are run: a free-running channel, a slow sender, a stalling
// receiver, and both at once.
// ----------------------------------------------------------------------------
module tb;
	import itoa_pkg::*;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
		logic       bad_radix;
	} text_word_t;

	typedef enum logic [1:0] {WANT_MODEL, WANT_TEXT, WANT_BAD} want_kind_t;

	typedef struct {
		logic [31:0] value;
		logic [4:0]  radix;
		want_kind_t  kind;
		string       text;
	} number_row_t;

	localparam int N_ROWS = 25;

	number_row_t directed_rows [0:N_ROWS-1] = '{
		'{32'd0,        5'd10, WANT_TEXT,  "0"},
		'{32'd0,        5'd2,  WANT_TEXT,  "0"},
		'{32'd1,        5'd2,  WANT_TEXT,  "1"},
		'{32'hFFFFFFFF, 5'd10, WANT_TEXT,  "-1"},
		'{32'h7FFFFFFF, 5'd10, WANT_TEXT,  "2147483647"},
		'{32'h80000000, 5'd10, WANT_TEXT,  "-2147483648"},
		'{32'h7FFFFFFF, 5'd16, WANT_TEXT,  "7FFFFFFF"},
		'{32'h80000000, 5'd16, WANT_TEXT,  "-80000000"},
		'{32'hFFFFFFFF, 5'd16, WANT_TEXT,  "-1"},
		'{32'd255,      5'd16, WANT_TEXT,  "FF"},
		'{32'h00ABCDEF, 5'd16, WANT_TEXT,  "ABCDEF"},
		'{32'd14,       5'd15, WANT_TEXT,  "E"},
		'{32'hFFFFFF01, 5'd16, WANT_TEXT,  "-FF"},
		'{32'd0,        5'd0,  WANT_BAD,   ""},
		'{32'd1,        5'd1,  WANT_BAD,   ""},
		'{32'd5,        5'd17, WANT_BAD,   ""},
		'{32'hFFFFFFF9, 5'd31, WANT_BAD,   ""},
		'{32'h80000000, 5'd2,  WANT_MODEL, ""},
		'{32'h7FFFFFFF, 5'd2,  WANT_MODEL, ""},
		'{32'h80000000, 5'd8,  WANT_MODEL, ""},
		'{32'd35,       5'd3,  WANT_MODEL, ""},
		'{32'd100,      5'd7,  WANT_MODEL, ""},
		'{32'hFFFFCFC7, 5'd9,  WANT_MODEL, ""},
		'{32'd15,       5'd15, WANT_MODEL, ""},
		'{32'd1000,     5'd5,  WANT_MODEL, ""}
	};

	localparam int RANDOM_PER_PHASE = 24;

	logic clk;
	logic arst_n;

	itoa_item_if item_bus ();
	itoa_text_if text_bus ();

	int_to_ascii_radix_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.text   (text_bus)
	);

	text_word_t expected_text [$];
	text_word_t want;

	// local copy of the converter state
	logic [31:0] conv_magnitude;
	logic [3:0]  conv_digits [0:MAX_DIGITS_DEF-1];
	logic [5:0]  conv_count;
	logic        conv_negative;

	int send_idle_pct;
	int recv_stall_pct;
	int numbers_sent;
	int bad_sent;
	int words_seen;
	int mismatches;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void push_word(input logic [7:0] ch, input logic last,
		input logic bad);
		text_word_t w;
		w.character = ch;
		w.last      = last;
		w.bad_radix = bad;
		expected_text.push_back(w);
	endfunction

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
		logic [7:0] ch;
		if (d >= 4'd10)
			ch = ALPHA_CHAR + {4'd0, d} - 8'd10;
		else
			ch = ZERO_CHAR + {4'd0, d};
		return ch;
	endfunction

	function automatic void convert_number(input logic [31:0] v, input logic [4:0] r);
		logic [31:0] m;
		logic [31:0] rem;
		int n;
		if (r < RADIX_MIN || r > RADIX_MAX) begin
			push_word(8'h00, 1'b1, 1'b1);
		end else begin
			conv_negative = v[31];
			m = conv_negative ? (~v + 32'd1) : v;
			conv_magnitude = m;
			n = 0;
			do begin
				rem = m % {27'd0, r};
				conv_digits[n] = rem[3:0];
				m = m / {27'd0, r};
				n++;
			end while (m != 0 && n < MAX_DIGITS_DEF);
			conv_count = 6'(n);
			if (conv_negative)
				push_word(MINUS_CHAR, 1'b0, 1'b0);
			for (int i = n - 1; i >= 0; i--)
				push_word(digit_to_ascii(conv_digits[i]), i == 0, 1'b0);
		end
	endfunction

	task automatic send_number(input logic [31:0] v, input logic [4:0] r,
		input want_kind_t kind, input string text);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.value <= v;
		item_bus.radix <= r;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		numbers_sent++;
		case (kind)
			WANT_TEXT: begin
				for (int i = 0; i < text.len(); i++)
					push_word(text[i], i == text.len() - 1, 1'b0);
			end
			WANT_BAD: begin
				push_word(8'h00, 1'b1, 1'b1);
				bad_sent++;
			end
			default: begin
				convert_number(v, r);
				if (r < RADIX_MIN || r > RADIX_MAX)
					bad_sent++;
			end
		endcase
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] v;
		case ($urandom_range(5, 0))
			0: v = $urandom_range(20, 0);
			1: v = -$urandom_range(20, 1);
			2: v = $urandom_range(3, 0) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
			3: v = $urandom_range(65535, 0);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] random_radix();
		logic [4:0] r;
		if ($urandom_range(9, 0) == 0) begin
			r = $urandom_range(1, 0) ? 5'($urandom_range(1, 0)) : 5'($urandom_range(31, 17));
		end else begin
			r = 5'($urandom_range(16, 2));
		end
		return r;
	endfunction

	always @(posedge clk)
		text_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && text_bus.valid && text_bus.ready) begin
			words_seen++;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected word char=%h last=%b bad_radix=%b", $time,
					text_bus.character, text_bus.last, text_bus.bad_radix);
				mismatches++;
			end else begin
				want = expected_text.pop_front();
				if (text_bus.character !== want.character) begin
					$display("%0t: character expected %h actual %h", $time,
						want.character, text_bus.character);
					mismatches++;
				end
				if (text_bus.last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time,
						want.last, text_bus.last);
					mismatches++;
				end
				if (text_bus.bad_radix !== want.bad_radix) begin
					$display("%0t: bad_radix expected %b actual %b", $time,
						want.bad_radix, text_bus.bad_radix);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("timeout with %0d words outstanding", expected_text.size());
		$display("** int_to_ascii_radix_top: FAILED **");
		$finish;
	end

	initial begin
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		numbers_sent   = 0;
		bad_sent       = 0;
		words_seen     = 0;
		mismatches     = 0;
		conv_magnitude = '0;
		conv_count     = '0;
		conv_negative  = 1'b0;
		arst_n         <= 1'b0;
		item_bus.valid <= 1'b0;
		item_bus.value <= '0;
		item_bus.radix <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_number(directed_rows[i].value, directed_rows[i].radix,
				directed_rows[i].kind, directed_rows[i].text);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				send_number(random_value(), random_radix(), WANT_MODEL, "");
		end
		item_bus.valid <= 1'b0;

		// drain, then watch for stray words
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("Converted %0d numbers, %0d of them with an out-of-range radix.",
			numbers_sent, bad_sent);
		$display("Checked %0d text words over four pacing phases, %0d mismatches.",
			words_seen, mismatches);
		if (mismatches == 0 && expected_text.size() == 0)
			$display("** int_to_ascii_radix_top: PASSED **");
		else
			$display("** int_to_ascii_radix_top: FAILED **");
		$finish;
	end

endmodule
